// ===== hdl/ksfc_pkg.sv =====
// ksfc_pkg: shared types, constants and defaults for the kalman state feedback controller
// no dependencies; used by ksfc_mac, the top level and the bench
package ksfc_pkg;

  // parameter defaults
  localparam int DRIVE_LIMIT_DEF = 4095;
  localparam int FRAC_BITS_DEF   = 16;

  // plant matrices, signed Q2.30
  localparam logic signed [31:0] A11 = 32'sd1073527076;
  localparam logic signed [31:0] A12 = 32'sd10725607;
  localparam logic signed [31:0] A21 = -32'sd37677601;
  localparam logic signed [31:0] A22 = 32'sd1071379592;
  localparam logic signed [31:0] B1  = 32'sd17008;
  localparam logic signed [31:0] B2  = 32'sd122729;

  // configuration register indexes
  localparam logic [2:0] CFG_TARGET_ANGLE  = 3'd0;
  localparam logic [2:0] CFG_ANGLE_OFFSET  = 3'd1;
  localparam logic [2:0] CFG_GAIN_ANGLE    = 3'd2;
  localparam logic [2:0] CFG_GAIN_RATE     = 3'd3;
  localparam logic [2:0] CFG_GAIN_INTEGRAL = 3'd4;
  localparam logic [2:0] CFG_PROCESS_NOISE = 3'd5;
  localparam logic [2:0] CFG_MEAS_NOISE    = 3'd6;
  localparam logic [2:0] CFG_INTEG_LIMIT   = 3'd7;

  // control of one multiply-accumulate request
  typedef struct packed {
    logic vld;  // request present
    logic clr;  // start a new sum
    logic sub;  // subtract the term
    logic shf;  // shift the product right by the fraction bits
  } mac_req_t;

endpackage

// ===== hdl/ksfc_mac.sv =====
// ksfc_mac: shared signed multiply-accumulate unit, product and sum registered
// depends on ksfc_pkg (mac_req_t)
module ksfc_mac #(
  parameter int AW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ksfc_pkg::mac_req_t         req,
  input  logic signed [AW-1:0]       opa,
  input  logic signed [31:0]         opb,
  output logic signed [AW+33:0]      acc
);
  localparam int PW   = AW + 32;
  localparam int ACCW = AW + 34;

  logic signed [PW-1:0]   prod_r;
  ksfc_pkg::mac_req_t     flg_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [ACCW-1:0] acc_nxt;
  logic signed [ACCW-1:0] term;
  logic signed [ACCW-1:0] base;

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r <= '0;
    end else begin
      flg_r <= req;
    end
    prod_r <= opa * opb;
  end

  // accumulate stage
  always_comb begin
    term    = flg_r.shf ? ACCW'(prod_r >>> FRAC_BITS) : ACCW'(prod_r);
    base    = flg_r.clr ? '0 : acc_r;
    acc_nxt = flg_r.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk) begin
    if (flg_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;
endmodule

// ===== hdl/ksfc_div.sv =====
// ksfc_div: signed restoring divider, one quotient bit per cycle, truncates toward zero
// no dependencies
module ksfc_div #(
  parameter int NW = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [32:0]   den,
  output logic                 done,
  output logic signed [NW:0]   quo
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [32:0]   rem_r;
  logic [32:0]   d_r;
  logic [NW-1:0] q_r;
  logic          neg_r;
  logic [33:0]   trial;
  logic [34:0]   diff;
  logic          ge;

  // trial subtract of one bit
  always_comb begin
    trial = {rem_r, q_r[NW-1]};
    diff  = {1'b0, trial} - {2'b00, d_r};
    ge    = !diff[34];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[NW-1] ? NW'(-num) : NW'(num);
      d_r   <= den[32] ? 33'(-den) : 33'(den);
      rem_r <= '0;
      neg_r <= num[NW-1] ^ den[32];
    end else if (busy_r) begin
      rem_r <= ge ? diff[32:0] : trial[32:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule

// ===== hdl/kalman_state_feedback_controller_unit.sv =====
// kalman_state_feedback_controller_unit: one angle sample in, one drive result out
// each result is computed by the shared multiply-accumulate sequence and by the bit-serial
// gain divider, which runs twice per sample
// a new sample is accepted only in the idle state; the input stalls until the result is registered
// reset: synchronous active-low rst_n restores configuration registers, estimates and covariance
// depends on ksfc_pkg, ksfc_mac, ksfc_div
module kalman_state_feedback_controller_unit #(
  parameter int DRIVE_LIMIT = ksfc_pkg::DRIVE_LIMIT_DEF,
  parameter int FRAC_BITS   = ksfc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         in_raw_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_drive_level,
  output logic               out_turn_clockwise,
  output logic               out_motor_halted,
  output logic signed [12:0] out_signed_drive,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_rate_estimate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int UW   = $clog2(DRIVE_LIMIT + 1) + FRAC_BITS + 1;
  localparam int AW   = (UW > 32) ? UW : 32;
  localparam int ACCW = AW + 34;
  localparam int NW   = 32 + FRAC_BITS;
  localparam logic signed [ACCW-1:0] U_LIM   = ACCW'(DRIVE_LIMIT) <<< FRAC_BITS;
  localparam logic signed [UW-1:0]   U_LIM_U = UW'(U_LIM);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN_A, S_DIV1, S_DIV2, S_RUN_B, S_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
    logic ok;
    ok = (v[ACCW-1:31] == '0) || (v[ACCW-1:31] == '1);
    if (ok) return v[31:0];
    return v[ACCW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // configuration registers
  logic signed [8:0]  target_r;
  logic [8:0]         offset_r;
  logic signed [31:0] gain_angle_r, gain_rate_r, gain_integral_r;
  logic [30:0]        proc_noise_r, meas_noise_r;
  logic [14:0]        integ_limit_r;

  // controller state
  state_t             state_r;
  logic [4:0]         step_r;
  logic signed [31:0] est1_r, est2_r, cov11_r, cov12_r, cov21_r, cov22_r;
  logic signed [15:0] es_r;

  // per-sample working values
  logic signed [9:0]    y_r;
  logic signed [UW-1:0] u_r;
  logic signed [31:0]   x1p_r, x2p_r, m11_r, m12_r, m21_r, m22_r;
  logic signed [31:0]   p11_r, p12_r, p21_r, p22_r, k1_r, k2_r, ye_r;

  // result register
  logic               out_valid_r;
  logic [11:0]        drive_level_r;
  logic               turn_cw_r, halted_r;
  logic signed [12:0] signed_drive_r;
  logic signed [31:0] angle_est_r, rate_est_r;

  // shared unit hookup
  ksfc_pkg::mac_req_t     req;
  logic signed [AW-1:0]   opa;
  logic signed [31:0]     opb;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] acc_s30;
  logic signed [ACCW-1:0] q_ext;
  logic signed [ACCW-1:0] u_clamp;
  logic                   div_start, div_done;
  logic signed [NW-1:0]   div_num;
  logic signed [32:0]     div_den;
  logic signed [NW:0]     div_quo;
  logic                   s_zero;

  // drive and integral helpers
  logic [UW-1:0]      u_mag;
  logic [16:0]        u_int_mag;
  logic [17:0]        u_int;
  logic signed [10:0] err;
  logic signed [16:0] es_sum, es_lim;
  logic signed [16:0] es_clamped;
  logic               u_at_pos, u_at_neg;

  ksfc_mac #(.AW(AW), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst_n(rst_n), .req(req), .opa(opa), .opb(opb), .acc(acc)
  );

  ksfc_div #(.NW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r        <= 9'sd0;
      offset_r        <= 9'd150;
      gain_angle_r    <= 32'sd2114591;
      gain_rate_r     <= 32'sd2400695;
      gain_integral_r <= -32'sd65379;
      proc_noise_r    <= 31'd655360;
      meas_noise_r    <= 31'd7;
      integ_limit_r   <= 15'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ksfc_pkg::CFG_TARGET_ANGLE:  target_r        <= cfg_data[8:0];
        ksfc_pkg::CFG_ANGLE_OFFSET:  offset_r        <= cfg_data[8:0];
        ksfc_pkg::CFG_GAIN_ANGLE:    gain_angle_r    <= cfg_data;
        ksfc_pkg::CFG_GAIN_RATE:     gain_rate_r     <= cfg_data;
        ksfc_pkg::CFG_GAIN_INTEGRAL: gain_integral_r <= cfg_data;
        ksfc_pkg::CFG_PROCESS_NOISE: proc_noise_r    <= cfg_data[30:0];
        ksfc_pkg::CFG_MEAS_NOISE:    meas_noise_r    <= cfg_data[30:0];
        ksfc_pkg::CFG_INTEG_LIMIT:   integ_limit_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // multiply-accumulate request schedule
  always_comb begin
    req = '0;
    opa = '0;
    opb = '0;
    if (state_r == S_RUN_A) begin
      case (step_r)
        5'd0:  begin req = '{1'b1, 1'b1, 1'b1, 1'b0}; opa = AW'(es_r);  opb = gain_integral_r; end
        5'd1:  begin req = '{1'b1, 1'b0, 1'b1, 1'b1}; opa = AW'(est1_r); opb = gain_angle_r; end
        5'd2:  begin req = '{1'b1, 1'b0, 1'b1, 1'b1}; opa = AW'(est2_r); opb = gain_rate_r; end
        5'd5:  begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(est1_r); opb = ksfc_pkg::A11; end
        5'd6:  begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(est2_r); opb = ksfc_pkg::A12; end
        5'd7:  begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(u_r);    opb = ksfc_pkg::B1; end
        5'd8:  begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(est1_r); opb = ksfc_pkg::A21; end
        5'd9:  begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(est2_r); opb = ksfc_pkg::A22; end
        5'd10: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(u_r);    opb = ksfc_pkg::B2; end
        5'd11: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(cov11_r); opb = ksfc_pkg::A11; end
        5'd12: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(cov21_r); opb = ksfc_pkg::A12; end
        5'd13: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(cov12_r); opb = ksfc_pkg::A11; end
        5'd14: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(cov22_r); opb = ksfc_pkg::A12; end
        5'd15: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(cov11_r); opb = ksfc_pkg::A21; end
        5'd16: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(cov21_r); opb = ksfc_pkg::A22; end
        5'd17: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(cov12_r); opb = ksfc_pkg::A21; end
        5'd18: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(cov22_r); opb = ksfc_pkg::A22; end
        5'd21: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(m11_r); opb = ksfc_pkg::A11; end
        5'd22: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(m12_r); opb = ksfc_pkg::A12; end
        5'd23: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(m11_r); opb = ksfc_pkg::A21; end
        5'd24: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(m12_r); opb = ksfc_pkg::A22; end
        5'd25: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(m21_r); opb = ksfc_pkg::A11; end
        5'd26: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(m22_r); opb = ksfc_pkg::A12; end
        5'd27: begin req = '{1'b1, 1'b1, 1'b0, 1'b0}; opa = AW'(m21_r); opb = ksfc_pkg::A21; end
        5'd28: begin req = '{1'b1, 1'b0, 1'b0, 1'b0}; opa = AW'(m22_r); opb = ksfc_pkg::A22; end
        default: ;
      endcase
    end else if (state_r == S_RUN_B) begin
      case (step_r)
        5'd0: begin req = '{1'b1, 1'b1, 1'b0, 1'b1}; opa = AW'(ye_r);  opb = k1_r; end
        5'd1: begin req = '{1'b1, 1'b1, 1'b0, 1'b1}; opa = AW'(ye_r);  opb = k2_r; end
        5'd2: begin req = '{1'b1, 1'b1, 1'b1, 1'b1}; opa = AW'(p11_r); opb = k1_r; end
        5'd3: begin req = '{1'b1, 1'b1, 1'b1, 1'b1}; opa = AW'(p12_r); opb = k1_r; end
        5'd4: begin req = '{1'b1, 1'b1, 1'b1, 1'b1}; opa = AW'(p11_r); opb = k2_r; end
        5'd5: begin req = '{1'b1, 1'b1, 1'b1, 1'b1}; opa = AW'(p12_r); opb = k2_r; end
        default: ;
      endcase
    end
  end

  // divider operands and write-back helpers
  always_comb begin
    div_num   = (state_r == S_DIV1) ? {p21_r, {FRAC_BITS{1'b0}}} : {p11_r, {FRAC_BITS{1'b0}}};
    div_den   = $signed(33'(p11_r)) + $signed({2'b00, meas_noise_r});
    s_zero    = (div_den == '0);
    div_start = ((state_r == S_RUN_A) && (step_r == 5'd30)) ||
                ((state_r == S_DIV1) && div_done);
    q_ext     = ACCW'(div_quo);
    acc_s30   = acc >>> 30;
    if (acc > U_LIM) begin
      u_clamp = U_LIM;
    end else if (acc < -U_LIM) begin
      u_clamp = -U_LIM;
    end else begin
      u_clamp = acc;
    end
  end

  // drive truncation and anti-windup
  always_comb begin
    u_mag      = u_r[UW-1] ? UW'(-u_r) : UW'(u_r);
    u_int_mag  = 17'(u_mag >> FRAC_BITS);
    u_int      = u_r[UW-1] ? -{1'b0, u_int_mag} : {1'b0, u_int_mag};
    err        = 11'(target_r) - 11'(y_r);
    u_at_pos   = (u_r == U_LIM_U);
    u_at_neg   = (u_r == -U_LIM_U);
    if (u_at_neg) begin
      es_sum = err[10] ? (17'(es_r) + 17'(err)) : 17'(es_r);
    end else if (u_at_pos) begin
      es_sum = (!err[10] && (err != '0)) ? (17'(es_r) + 17'(err)) : 17'(es_r);
    end else begin
      es_sum = 17'(es_r) + 17'(err);
    end
    es_lim = $signed({2'b00, integ_limit_r});
    if (es_sum > es_lim) begin
      es_clamped = es_lim;
    end else if (es_sum < -es_lim) begin
      es_clamped = -es_lim;
    end else begin
      es_clamped = es_sum;
    end
  end

  // sequencer with state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      est1_r      <= '0;
      est2_r      <= '0;
      cov11_r     <= 32'sd1 <<< FRAC_BITS;
      cov12_r     <= '0;
      cov21_r     <= '0;
      cov22_r     <= 32'sd1 <<< FRAC_BITS;
      es_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            y_r     <= $signed({1'b0, in_raw_angle}) - $signed({1'b0, offset_r});
            step_r  <= '0;
            state_r <= S_RUN_A;
          end
        end
        S_RUN_A: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            5'd4:  u_r   <= UW'(u_clamp);
            5'd9:  x1p_r <= sat32(acc_s30);
            5'd12: x2p_r <= sat32(acc_s30);
            5'd14: m11_r <= sat32(acc_s30);
            5'd16: m12_r <= sat32(acc_s30);
            5'd18: m21_r <= sat32(acc_s30);
            5'd20: m22_r <= sat32(acc_s30);
            5'd24: p11_r <= sat32(acc_s30 + ACCW'($signed({1'b0, proc_noise_r})));
            5'd26: p12_r <= sat32(acc_s30);
            5'd28: p21_r <= sat32(acc_s30);
            5'd30: begin
              p22_r   <= sat32(acc_s30 + ACCW'($signed({1'b0, proc_noise_r})));
              ye_r    <= sat32((ACCW'(y_r) <<< FRAC_BITS) - ACCW'(x1p_r));
              state_r <= S_DIV1;
            end
            default: ;
          endcase
        end
        S_DIV1: begin
          if (div_done) begin
            k1_r    <= s_zero ? 32'sd0 : sat32(q_ext);
            state_r <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            k2_r    <= s_zero ? 32'sd0 : sat32(q_ext);
            step_r  <= '0;
            state_r <= S_RUN_B;
          end
        end
        S_RUN_B: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            5'd2: est1_r  <= sat32(acc + ACCW'(x1p_r));
            5'd3: est2_r  <= sat32(acc + ACCW'(x2p_r));
            5'd4: cov11_r <= sat32(acc + ACCW'(p11_r));
            5'd5: cov12_r <= sat32(acc + ACCW'(p12_r));
            5'd6: cov21_r <= sat32(acc + ACCW'(p21_r));
            5'd7: begin
              cov22_r <= sat32(acc + ACCW'(p22_r));
              state_r <= S_FIN;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            drive_level_r  <= u_int_mag[11:0];
            turn_cw_r      <= (u_r[UW-1] || (u_r == '0));
            halted_r       <= (u_r == '0);
            signed_drive_r <= u_int[12:0];
            angle_est_r    <= est1_r;
            rate_est_r     <= est2_r;
            es_r           <= 16'(es_clamped);
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_level    = drive_level_r;
  assign out_turn_clockwise = turn_cw_r;
  assign out_motor_halted   = halted_r;
  assign out_signed_drive   = signed_drive_r;
  assign out_angle_estimate = angle_est_r;
  assign out_rate_estimate  = rate_est_r;
endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for the kalman state feedback controller unit
// depends on ksfc_pkg and kalman_state_feedback_controller_unit
module tb;

  localparam int FB = ksfc_pkg::FRAC_BITS_DEF;
  localparam longint DLIM = longint'(ksfc_pkg::DRIVE_LIMIT_DEF) << FB;

  typedef struct packed {
    logic [11:0]        level;
    logic               cw;
    logic               halted;
    logic signed [12:0] drive;
    logic signed [31:0] ang;
    logic signed [31:0] rate;
  } drive_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [8:0] in_raw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_drive_level;
  logic out_turn_clockwise, out_motor_halted;
  logic signed [12:0] out_signed_drive;
  logic signed [31:0] out_angle_estimate, out_rate_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  kalman_state_feedback_controller_unit dut (.*);

  always #2 clk = ~clk;

  // predictor state and configuration
  longint tgt, offs, g_ang, g_rate, g_int, q_noise, r_noise, i_lim;
  longint x1, x2, c11, c12, c21, c22, esum;

  logic [8:0] angle_q[$];
  drive_res_t expect_q[$];
  int errors = 0;
  int watchdog = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      ksfc_pkg::CFG_TARGET_ANGLE:  tgt = longint'($signed(d[8:0]));
      ksfc_pkg::CFG_ANGLE_OFFSET:  offs = longint'(d[8:0]);
      ksfc_pkg::CFG_GAIN_ANGLE:    g_ang = longint'($signed(d));
      ksfc_pkg::CFG_GAIN_RATE:     g_rate = longint'($signed(d));
      ksfc_pkg::CFG_GAIN_INTEGRAL: g_int = longint'($signed(d));
      ksfc_pkg::CFG_PROCESS_NOISE: q_noise = longint'(d[30:0]);
      ksfc_pkg::CFG_MEAS_NOISE:    r_noise = longint'(d[30:0]);
      ksfc_pkg::CFG_INTEG_LIMIT:   i_lim = longint'(d[14:0]);
      default: ;
    endcase
  endfunction

  // one control period of the filter and controller
  function automatic drive_res_t control_step(logic [8:0] raw);
    longint y, err, u, x1p, x2p, m11, m12, m21, m22, p11, p12, p21, p22;
    longint s, k1, k2, ye, ui, acc;
    longint a11, a12, a21, a22, b1, b2;
    drive_res_t r;
    a11 = longint'(ksfc_pkg::A11);
    a12 = longint'(ksfc_pkg::A12);
    a21 = longint'(ksfc_pkg::A21);
    a22 = longint'(ksfc_pkg::A22);
    b1 = longint'(ksfc_pkg::B1);
    b2 = longint'(ksfc_pkg::B2);
    y = longint'(raw) - offs;
    err = tgt - y;
    u = -(g_int * esum) - ((g_ang * x1) >>> FB) - ((g_rate * x2) >>> FB);
    if (u > DLIM) u = DLIM;
    else if (u < -DLIM) u = -DLIM;
    x1p = sat32((a11 * x1 + a12 * x2 + b1 * u) >>> 30);
    x2p = sat32((a21 * x1 + a22 * x2 + b2 * u) >>> 30);
    m11 = sat32((a11 * c11 + a12 * c21) >>> 30);
    m12 = sat32((a11 * c12 + a12 * c22) >>> 30);
    m21 = sat32((a21 * c11 + a22 * c21) >>> 30);
    m22 = sat32((a21 * c12 + a22 * c22) >>> 30);
    p11 = sat32(((m11 * a11 + m12 * a12) >>> 30) + q_noise);
    p12 = sat32((m11 * a21 + m12 * a22) >>> 30);
    p21 = sat32((m21 * a11 + m22 * a12) >>> 30);
    p22 = sat32(((m21 * a21 + m22 * a22) >>> 30) + q_noise);
    s = p11 + r_noise;
    k1 = 0;
    k2 = 0;
    if (s != 0) begin
      k1 = sat32((p11 <<< FB) / s);
      k2 = sat32((p21 <<< FB) / s);
    end
    ye = sat32((y <<< FB) - x1p);
    x1 = sat32(x1p + ((k1 * ye) >>> FB));
    x2 = sat32(x2p + ((k2 * ye) >>> FB));
    c11 = sat32(p11 - ((k1 * p11) >>> FB));
    c12 = sat32(p12 - ((k1 * p12) >>> FB));
    c21 = sat32(p21 - ((k2 * p11) >>> FB));
    c22 = sat32(p22 - ((k2 * p12) >>> FB));
    ui = (u < 0) ? -((-u) >> FB) : (u >> FB);
    r.level = (ui < 0) ? 12'(-ui) : 12'(ui);
    r.cw = (u <= 0);
    r.halted = (u == 0);
    r.drive = 13'(ui);
    r.ang = 32'(x1);
    r.rate = 32'(x2);
    // conditional anti-windup, then clamp
    acc = esum;
    if (u == -DLIM) begin
      if (err < 0) acc += err;
    end else if (u == DLIM) begin
      if (err > 0) acc += err;
    end else begin
      acc += err;
    end
    if (acc > i_lim) acc = i_lim;
    else if (acc < -i_lim) acc = -i_lim;
    esum = acc;
    return r;
  endfunction

  // request driver with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expect_q.push_back(control_step(in_raw_angle));
        send_gap = $urandom_range(0, 4);
        if (send_gap == 0 && angle_q.size() > 0) begin
          in_raw_angle <= angle_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else if (angle_q.size() > 0) begin
          in_raw_angle <= angle_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // result monitor with random stalls
  int recv_gap = 0;
  always @(posedge clk) begin
    drive_res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = expect_q.pop_front();
          if (out_drive_level !== e.level) begin
            $error("drive_level exp %0d got %0d", e.level, out_drive_level);
            errors++;
          end
          if (out_turn_clockwise !== e.cw) begin
            $error("turn_clockwise exp %0d got %0d", e.cw, out_turn_clockwise);
            errors++;
          end
          if (out_motor_halted !== e.halted) begin
            $error("motor_halted exp %0d got %0d", e.halted, out_motor_halted);
            errors++;
          end
          if (out_signed_drive !== e.drive) begin
            $error("signed_drive exp %0d got %0d", e.drive, out_signed_drive);
            errors++;
          end
          if (out_angle_estimate !== e.ang) begin
            $error("angle_estimate exp %0d got %0d", e.ang, out_angle_estimate);
            errors++;
          end
          if (out_rate_estimate !== e.rate) begin
            $error("rate_estimate exp %0d got %0d", e.rate, out_rate_estimate);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
        out_stall <= (recv_gap > 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= (recv_gap > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        (angle_q.size() == 0 && expect_q.size() == 0 && !in_valid))
      watchdog <= 0;
    else
      watchdog <= watchdog + 1;
    if (watchdog > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_idle();
    while (angle_q.size() > 0 || in_valid || expect_q.size() > 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // randomized settings; extremes on some phases
  task automatic pick_settings(int mode);
    logic [31:0] t;
    t = (mode == 1) ? 32'h100 : (mode == 2) ? 32'd180 : 32'($signed($urandom_range(0, 360)) - 180);
    write_reg(ksfc_pkg::CFG_TARGET_ANGLE, t);
    write_reg(ksfc_pkg::CFG_ANGLE_OFFSET, (mode == 1) ? 32'h1FF : (mode == 2) ? 32'd0
                                          : $urandom_range(0, 359));
    write_reg(ksfc_pkg::CFG_GAIN_ANGLE, (mode == 1) ? 32'h8000_0000 : (mode == 2) ? 32'h7FFF_FFFF
                                        : $urandom_range(0, 6000000) - 1000000);
    write_reg(ksfc_pkg::CFG_GAIN_RATE, (mode == 1) ? 32'h7FFF_FFFF : (mode == 2) ? 32'h8000_0000
                                       : $urandom_range(0, 6000000) - 1000000);
    write_reg(ksfc_pkg::CFG_GAIN_INTEGRAL, (mode == 1) ? 32'h8000_0000
                                           : (mode == 2) ? 32'h7FFF_FFFF
                                           : $urandom_range(0, 400000) - 200000);
    write_reg(ksfc_pkg::CFG_PROCESS_NOISE, (mode == 1) ? 32'hFFFF_FFFF : (mode == 2) ? 32'd0
                                           : $urandom_range(0, 2000000));
    write_reg(ksfc_pkg::CFG_MEAS_NOISE, (mode == 1) ? 32'h7FFF_FFFF : (mode == 2) ? 32'd1
                                        : $urandom_range(1, 200000));
    write_reg(ksfc_pkg::CFG_INTEG_LIMIT, (mode == 1) ? 32'hFFFF : (mode == 2) ? 32'd0
                                         : $urandom_range(0, 3000));
  endtask

  initial begin
    apply_cfg(ksfc_pkg::CFG_TARGET_ANGLE, 0);
    apply_cfg(ksfc_pkg::CFG_ANGLE_OFFSET, 150);
    apply_cfg(ksfc_pkg::CFG_GAIN_ANGLE, 2114591);
    apply_cfg(ksfc_pkg::CFG_GAIN_RATE, 2400695);
    apply_cfg(ksfc_pkg::CFG_GAIN_INTEGRAL, -65379);
    apply_cfg(ksfc_pkg::CFG_PROCESS_NOISE, 655360);
    apply_cfg(ksfc_pkg::CFG_MEAS_NOISE, 7);
    apply_cfg(ksfc_pkg::CFG_INTEG_LIMIT, 1000);
    x1 = 0; x2 = 0; c11 = 64'sd1 <<< FB; c12 = 0; c21 = 0; c22 = 64'sd1 <<< FB; esum = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset settings, field extremes and out-of-range angles
    angle_q.push_back(9'd0);
    angle_q.push_back(9'd359);
    angle_q.push_back(9'd511);
    angle_q.push_back(9'd150);
    angle_q.push_back(9'd256);
    angle_q.push_back(9'd255);
    for (int i = 0; i < 8; i++) angle_q.push_back(9'(i * 64 + 1));
    wait_idle();
    // extreme settings: saturation, full drive and zero integral window
    pick_settings(1);
    for (int i = 0; i < 6; i++) angle_q.push_back(9'($urandom));
    wait_idle();
    pick_settings(2);
    for (int i = 0; i < 6; i++) angle_q.push_back(9'($urandom_range(0, 359)));
    wait_idle();
    // random phases with fresh settings
    for (int ph = 0; ph < 14; ph++) begin
      pick_settings(0);
      for (int i = 0; i < 100; i++)
        angle_q.push_back(($urandom_range(0, 19) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359)));
      wait_idle();
    end
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
